// File: src/hll_pkg.sv
// Shared widths, defaults and a helper function for the sketch update block.
package hll_pkg;

  localparam int BUCKET_BITS_DEF = 14;
  localparam int HASH_W          = 32;
  localparam int RANK_W          = 5;
  localparam int REG_W           = 6;
  localparam int WEIGHT_W        = 33;
  localparam int SUM_W           = 49;
  localparam int SUM_OUT_W       = 47;
  localparam int ZCNT_W          = 17;
  localparam int ZERO_OUT_W      = 15;
  localparam int FRAC_BITS       = 32;

  // Weight 2^-reg with 32 fraction bits; zero for registers beyond the fraction.
  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [REG_W-1:0] reg_val);
    logic [WEIGHT_W-1:0] w;
    if (reg_val > REG_W'(FRAC_BITS)) begin
      w = '0;
    end else begin
      w = WEIGHT_W'(1) << (REG_W'(FRAC_BITS) - reg_val);
    end
    return w;
  endfunction

endpackage

// File: src/hll_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/hll_rank.sv
// Rank encoder: one plus the leading zeros of the hash bits below the bucket index.
module hll_rank #(
  parameter int BUCKET_BITS = hll_pkg::BUCKET_BITS_DEF
) (
  input  logic [hll_pkg::HASH_W-1:0] hash,
  output logic [hll_pkg::RANK_W-1:0] rank
);

  localparam int REST_W = hll_pkg::HASH_W - BUCKET_BITS;

  logic [REST_W-1:0] rest;

  assign rest = hash[REST_W-1:0];

  always_comb begin
    rank = hll_pkg::RANK_W'(REST_W + 1);
    for (int i = 0; i < REST_W; i++) begin
      if (rest[i]) begin
        rank = hll_pkg::RANK_W'(REST_W - i);
      end
    end
  end

endmodule

// File: src/hyperloglog_sketch_update_core.sv
// Top level of the sketch update block: bucket store, update stage and running sums.
//
// Input channel: in_hash with in_valid/in_ready; one word per hash.
// Output channel: out_rank, out_updated, out_harmonic_sum, out_zero_buckets
// with out_valid/out_ready; exactly one output word per input word, in order.
// The top BUCKET_BITS hash bits address a bucket in a synchronous RAM.
// The RAM is read in the cycle a hash is accepted; the update stage then compares,
// and when it advances writes the raised bucket back and updates the running sums.
// A write that is still the latest to the same bucket is forwarded.
// The output word is registered: the hash passes the update stage and then the
// output register, and a receiver stall can hold it in either.
// Throughput is one word per cycle while out_ready is high, set by the single RAM
// read and write port. After reset the bucket RAM is cleared one entry per cycle,
// all 2^BUCKET_BITS entries (16384 by default); in_ready stays low meanwhile.
// When the receiver stalls, the output register holds its word and one more
// hash can be accepted into the update stage before in_ready drops.
// The harmonic sum and zero count saturate at their all-ones output values.
module hyperloglog_sketch_update_core #(
  parameter int BUCKET_BITS = hll_pkg::BUCKET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hll_pkg::HASH_W-1:0]       in_hash,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hll_pkg::RANK_W-1:0]       out_rank,
  output logic                             out_updated,
  output logic [hll_pkg::SUM_OUT_W-1:0]    out_harmonic_sum,
  output logic [hll_pkg::ZERO_OUT_W-1:0]   out_zero_buckets
);

  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam logic [hll_pkg::SUM_W-1:0] SUM_INIT =
    hll_pkg::SUM_W'(NUM_BUCKETS) << hll_pkg::FRAC_BITS;
  localparam logic [hll_pkg::ZCNT_W-1:0] ZCNT_INIT = hll_pkg::ZCNT_W'(NUM_BUCKETS);

  logic                          clearing_r;
  logic [BUCKET_BITS-1:0]        clr_cnt_r;

  logic                          s1_valid_r;
  logic [BUCKET_BITS-1:0]        s1_idx_r;
  logic [hll_pkg::RANK_W-1:0]    s1_rank_r;

  logic                          lw_valid_r;
  logic [BUCKET_BITS-1:0]        lw_idx_r;
  logic [hll_pkg::REG_W-1:0]     lw_val_r;

  logic                          out_valid_r;
  logic [hll_pkg::RANK_W-1:0]    out_rank_r;
  logic                          out_upd_r;
  logic [hll_pkg::SUM_W-1:0]     sum_r;
  logic [hll_pkg::ZCNT_W-1:0]    zcnt_r;

  logic                          in_acc;
  logic                          s1_adv;
  logic [hll_pkg::RANK_W-1:0]    in_rank;
  logic [BUCKET_BITS-1:0]        in_idx;
  logic [hll_pkg::REG_W-1:0]     ram_rdata;
  logic [hll_pkg::REG_W-1:0]     cur;
  logic [hll_pkg::REG_W-1:0]     rank_ext;
  logic                          raise;
  logic [hll_pkg::WEIGHT_W-1:0]  w_diff;
  logic [hll_pkg::SUM_W-1:0]     sum_nxt;
  logic [hll_pkg::ZCNT_W-1:0]    zcnt_nxt;
  logic                          ram_we;
  logic [BUCKET_BITS-1:0]        ram_waddr;
  logic [hll_pkg::REG_W-1:0]     ram_wdata;

  assign in_idx   = in_hash[hll_pkg::HASH_W-1 -: BUCKET_BITS];
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_acc   = in_valid && in_ready;

  hll_rank #(
    .BUCKET_BITS(BUCKET_BITS)
  ) u_rank (
    .hash(in_hash),
    .rank(in_rank)
  );

  assign cur      = (lw_valid_r && (lw_idx_r == s1_idx_r)) ? lw_val_r : ram_rdata;
  assign rank_ext = hll_pkg::REG_W'(s1_rank_r);
  assign raise    = rank_ext > cur;
  assign w_diff   = hll_pkg::weight_of(cur) - hll_pkg::weight_of(rank_ext);

  always_comb begin
    sum_nxt  = sum_r;
    zcnt_nxt = zcnt_r;
    if (raise) begin
      sum_nxt = sum_r - hll_pkg::SUM_W'(w_diff);
      if ((cur == '0) && (zcnt_r != '0)) begin
        zcnt_nxt = zcnt_r - hll_pkg::ZCNT_W'(1);
      end
    end
  end

  assign ram_we    = clearing_r || (s1_adv && raise);
  assign ram_waddr = clearing_r ? clr_cnt_r : s1_idx_r;
  assign ram_wdata = clearing_r ? '0 : rank_ext;

  hll_ram #(
    .WIDTH(hll_pkg::REG_W),
    .DEPTH(NUM_BUCKETS)
  ) u_bucket_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_acc),
    .raddr(in_idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= SUM_INIT;
      zcnt_r      <= ZCNT_INIT;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + BUCKET_BITS'(1);
        if (clr_cnt_r == '1) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && raise) begin
        lw_valid_r <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        sum_r       <= sum_nxt;
        zcnt_r      <= zcnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r  <= in_idx;
      s1_rank_r <= in_rank;
    end
    if (s1_adv && raise) begin
      lw_idx_r <= s1_idx_r;
      lw_val_r <= rank_ext;
    end
    if (s1_adv) begin
      out_rank_r <= s1_rank_r;
      out_upd_r  <= raise;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rank         = out_rank_r;
  assign out_updated      = out_upd_r;
  assign out_harmonic_sum = (sum_r[hll_pkg::SUM_W-1:hll_pkg::SUM_OUT_W] != '0) ?
                            '1 : sum_r[hll_pkg::SUM_OUT_W-1:0];
  assign out_zero_buckets = (zcnt_r[hll_pkg::ZCNT_W-1:hll_pkg::ZERO_OUT_W] != '0) ?
                            '1 : zcnt_r[hll_pkg::ZERO_OUT_W-1:0];

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_ready)
    else $error("hash word accepted while the bucket RAM is being cleared");

  a_zero_count_falls: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> zcnt_r <= $past(zcnt_r))
    else $error("zero bucket count increased");

  a_sum_falls: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> sum_r <= $past(sum_r))
    else $error("harmonic sum increased");

  a_update_raises: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && raise) |=> (sum_r != $past(sum_r)) && out_updated)
    else $error("raised bucket did not change the harmonic sum");
`endif

endmodule

// File: sim/tb_hyperloglog_sketch_update_core.sv
// Self-checking testbench for the HyperLogLog sketch update core.
`timescale 1ns / 1ps

module tb_hyperloglog_sketch_update_core;

  localparam int IDX_W          = hll_pkg::BUCKET_BITS_DEF;
  localparam int REST_W         = hll_pkg::HASH_W - IDX_W;
  localparam int NUM_BUCKETS    = 1 << IDX_W;
  localparam int MAX_RANK       = REST_W + 1;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [hll_pkg::RANK_W-1:0]     rank;
    logic                           updated;
    logic [hll_pkg::SUM_OUT_W-1:0]  hsum;
    logic [hll_pkg::ZERO_OUT_W-1:0] zeros;
  } sketch_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [hll_pkg::HASH_W-1:0]     in_hash = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [hll_pkg::RANK_W-1:0]     out_rank;
  logic                           out_updated;
  logic [hll_pkg::SUM_OUT_W-1:0]  out_harmonic_sum;
  logic [hll_pkg::ZERO_OUT_W-1:0] out_zero_buckets;

  logic [hll_pkg::REG_W-1:0]  bucket_regs [NUM_BUCKETS];
  logic [hll_pkg::SUM_W-1:0]  sum_track;
  logic [hll_pkg::ZCNT_W-1:0] zero_track;
  sketch_word_t               expected_words [$];

  int  error_count = 0;
  int  hashes_sent = 0;
  int  words_checked = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  in_idle_on = 1'b0;
  bit  out_idle_on = 1'b0;

  hyperloglog_sketch_update_core #(
    .BUCKET_BITS(IDX_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_hash          (in_hash),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rank         (out_rank),
    .out_updated      (out_updated),
    .out_harmonic_sum (out_harmonic_sum),
    .out_zero_buckets (out_zero_buckets)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [hll_pkg::SUM_W-1:0] reg_weight(
    input logic [hll_pkg::REG_W-1:0] r);
    if (int'(r) > hll_pkg::FRAC_BITS) begin
      return '0;
    end
    return hll_pkg::SUM_W'(1) << (hll_pkg::FRAC_BITS - int'(r));
  endfunction

  function automatic void clear_sketch();
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      bucket_regs[i] = '0;
    end
    sum_track  = hll_pkg::SUM_W'(NUM_BUCKETS) << hll_pkg::FRAC_BITS;
    zero_track = hll_pkg::ZCNT_W'(NUM_BUCKETS);
  endfunction

  // Applies one hash to the predicted sketch and queues the word it should produce.
  function automatic void fold_hash(input logic [hll_pkg::HASH_W-1:0] h);
    logic [IDX_W-1:0]           idx;
    logic [hll_pkg::HASH_W-1:0] rest;
    logic [hll_pkg::REG_W-1:0]  cur;
    logic [hll_pkg::RANK_W-1:0] rk;
    bit                         found;
    sketch_word_t               w;
    idx   = h[hll_pkg::HASH_W-1 -: IDX_W];
    rest  = h << IDX_W;
    rk    = hll_pkg::RANK_W'(1);
    found = 1'b0;
    for (int i = 0; i < REST_W; i++) begin
      if (!found && rest[hll_pkg::HASH_W-1]) begin
        found = 1'b1;
      end else if (!found) begin
        rk   = rk + hll_pkg::RANK_W'(1);
        rest = rest << 1;
      end
    end
    cur       = bucket_regs[idx];
    w.updated = 1'b0;
    if (hll_pkg::REG_W'(rk) > cur) begin
      sum_track = sum_track - reg_weight(cur) + reg_weight(hll_pkg::REG_W'(rk));
      if (cur == '0 && zero_track != '0) begin
        zero_track = zero_track - hll_pkg::ZCNT_W'(1);
      end
      bucket_regs[idx] = hll_pkg::REG_W'(rk);
      w.updated = 1'b1;
    end
    w.rank  = rk;
    w.hsum  = (sum_track > hll_pkg::SUM_W'({hll_pkg::SUM_OUT_W{1'b1}})) ?
              '1 : sum_track[hll_pkg::SUM_OUT_W-1:0];
    w.zeros = (zero_track > hll_pkg::ZCNT_W'({hll_pkg::ZERO_OUT_W{1'b1}})) ?
              '1 : zero_track[hll_pkg::ZERO_OUT_W-1:0];
    expected_words.push_back(w);
  endfunction

  // Builds a hash for a given bucket whose remaining bits give the requested rank.
  function automatic logic [hll_pkg::HASH_W-1:0] make_hash(input logic [IDX_W-1:0] idx,
                                                          input int rk);
    logic [REST_W-1:0] rest;
    logic [REST_W-1:0] noise;
    logic [REST_W-1:0] lead;
    noise = REST_W'($urandom);
    if (rk >= MAX_RANK) begin
      rest = '0;
    end else begin
      lead = REST_W'(1) << (REST_W - rk);
      rest = lead | (noise & (lead - REST_W'(1)));
    end
    return {idx, rest};
  endfunction

  task automatic send_hash(input logic [hll_pkg::HASH_W-1:0] h);
    int gap;
    @(negedge clk);
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_hash  <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fold_hash(h);
    hashes_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_ranks();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    send_hash(32'h0000_0000);
    send_hash(32'hFFFF_FFFF);
    send_hash(32'hFFFF_FFFF);
    for (int r = 1; r <= MAX_RANK; r++) begin
      send_hash(make_hash(IDX_W'(1), r));
    end
    send_hash(make_hash(IDX_W'(1), 7));
    drain_results();
  endtask

  task automatic test_hot_buckets(input int count);
    logic [IDX_W-1:0] pool [8];
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < 8; i++) begin
      pool[i] = IDX_W'($urandom);
    end
    for (int i = 0; i < count; i++) begin
      send_hash(make_hash(pool[$urandom_range(0, 7)], $urandom_range(1, MAX_RANK)));
    end
    drain_results();
  endtask

  task automatic test_spread_hashes(input int count);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_hash($urandom);
    end
    drain_results();
  endtask

  task automatic test_same_bucket_bursts(input int count);
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    int               sent;
    int               len;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b1;
    sent = 0;
    while (sent < count) begin
      a   = IDX_W'($urandom);
      b   = IDX_W'($urandom);
      len = $urandom_range(2, 6);
      for (int i = 0; i < len; i++) begin
        send_hash(make_hash(($urandom_range(0, 3) == 0) ? b : a, $urandom_range(1, MAX_RANK)));
      end
      sent += len;
    end
    drain_results();
  endtask

  task automatic test_full_rate(input int count);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_hash($urandom);
      end else begin
        send_hash(make_hash(IDX_W'($urandom_range(0, 15)), $urandom_range(1, MAX_RANK)));
      end
    end
    drain_results();
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (stall_left == 0 && out_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sketch_word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("ERROR: output word with no hash pending: rank %0d sum %0h zeros %0d",
                   out_rank, out_harmonic_sum, out_zero_buckets);
        end
      end else begin
        want = expected_words.pop_front();
        if (out_rank !== want.rank || out_updated !== want.updated ||
            out_harmonic_sum !== want.hsum || out_zero_buckets !== want.zeros) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("ERROR: word %0d expected rank %0d upd %0b sum %0h zeros %0d", words_checked,
                     want.rank, want.updated, want.hsum, want.zeros);
            $display("       got      rank %0d upd %0b sum %0h zeros %0d",
                     out_rank, out_updated, out_harmonic_sum, out_zero_buckets);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timed out with %0d words outstanding.", expected_words.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    clear_sketch();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_ranks();
    test_hot_buckets(600);
    test_spread_hashes(450);
    test_same_bucket_bursts(330);
    test_full_rate(250);

    repeat (8) @(posedge clk);
    error_count += expected_words.size();
    $display("Checked %0d words from %0d hashes: every rank, repeats on a few hot buckets,",
             words_checked, hashes_sent);
    $display("spread random hashes and back-to-back updates of one bucket, with and without stalls.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches.", error_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
src/hll_pkg.sv
src/hll_ram.sv
src/hll_rank.sv
src/hyperloglog_sketch_update_core.sv
sim/tb_hyperloglog_sketch_update_core.sv
